>>> rtl/char_lcd_write_sequencer_macros.svh
// -----------------------------------------------------------------------------
// char_lcd_write_sequencer_macros
// Assertion macros shared by the LCD write sequencer RTL.
// -----------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lws_pkg.sv
// -----------------------------------------------------------------------------
// lws_pkg
// Types, codes and command tables of the character LCD write sequencer.
// -----------------------------------------------------------------------------
package lws_pkg;

  // Request operation codes
  localparam logic [2:0] OP_CMD    = 3'd0;
  localparam logic [2:0] OP_DATA   = 3'd1;
  localparam logic [2:0] OP_CURSOR = 3'd2;
  localparam logic [2:0] OP_NUMBER = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;

  // Display geometry: rows past the last one clamp to it
  localparam int NUM_ROWS = 4;

  // Serial divider geometry
  localparam int DIV_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  // Power-up sequence lengths
  localparam logic [2:0] INIT4_LEN = 3'd7;
  localparam logic [2:0] INIT8_LEN = 3'd5;

  // ASCII zero
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_BYTE
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic       done;
    logic       q_nz;
    logic [3:0] digit;
  } div_stat_t;

  // Digit stack controls
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  // DDRAM base address of each display row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h90;
      default: base = 8'hD0;
    endcase
    return base;
  endfunction

  // Power-up command sequence, 4-bit or 8-bit bus
  function automatic logic [7:0] init_cmd(input logic four_bit, input logic [2:0] idx);
    logic [7:0] cmd;
    if (four_bit) begin
      unique case (idx)
        3'd0:    cmd = 8'h33;
        3'd1:    cmd = 8'h32;
        3'd2:    cmd = 8'h28;
        3'd3:    cmd = 8'h0C;
        3'd4:    cmd = 8'h02;
        3'd5:    cmd = 8'h01;
        default: cmd = 8'h06;
      endcase
    end else begin
      unique case (idx)
        3'd0:    cmd = 8'h38;
        3'd1:    cmd = 8'h0C;
        3'd2:    cmd = 8'h02;
        3'd3:    cmd = 8'h01;
        default: cmd = 8'h06;
      endcase
    end
    return cmd;
  endfunction

endpackage

>>> rtl/lws_div10.sv
// -----------------------------------------------------------------------------
// lws_div10
// Bit-serial divide by ten: one quotient bit per cycle, restoring remainder.
// -----------------------------------------------------------------------------
module lws_div10
  import lws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output div_stat_t        stat,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]  shreg_r, shreg_nxt;
  logic [3:0]        rem_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic              nz_r, nz_nxt;
  logic [4:0]        trial;
  logic              ge;

  // Bring down the next dividend bit and try subtracting ten
  assign trial = {rem_r, shreg_r[DIV_W-1]};
  assign ge    = (trial >= 5'd10);

  always_comb begin
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    nz_nxt    = nz_r;
    priority if (start) begin
      shreg_nxt = dividend;
      rem_nxt   = 4'd0;
      cnt_nxt   = '0;
      run_nxt   = 1'b1;
      nz_nxt    = 1'b0;
    end else if (run_r) begin
      shreg_nxt = {shreg_r[DIV_W-2:0], ge};
      rem_nxt   = ge ? 4'(trial - 5'd10) : trial[3:0];
      nz_nxt    = nz_r | ge;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      // hold the last result while idle
      run_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    nz_r    <= nz_nxt;
  end

  assign stat.done  = done_r;
  assign stat.q_nz  = nz_r;
  assign stat.digit = rem_r;
  assign busy       = run_r;
  assign quotient   = shreg_r;

endmodule

>>> rtl/lws_dstack.sv
// -----------------------------------------------------------------------------
// lws_dstack
// Shift-register digit stack: digits enter least significant first and
// leave most significant first.
// -----------------------------------------------------------------------------
module lws_dstack
  import lws_pkg::*;
#(
  parameter int MAX_DIGITS = 10,
  localparam int CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_ctl_t      ctl,
  input  logic [3:0]    digit_in,
  output logic [3:0]    top,
  output logic [CW-1:0] count
);

  logic [3:0]    dig_r [MAX_DIGITS];
  logic [3:0]    dig_nxt [MAX_DIGITS];
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Push shifts up, pop shifts down
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig_nxt[i] = dig_r[i];
    end
    cnt_nxt = cnt_r;
    priority if (ctl.push) begin
      for (int i = 1; i < MAX_DIGITS; i++) begin
        dig_nxt[i] = dig_r[i-1];
      end
      dig_nxt[0] = digit_in;
      cnt_nxt    = cnt_r + 1'b1;
    end else if (ctl.pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        dig_nxt[i] = dig_r[i+1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      // hold the stack
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig_r[i] <= dig_nxt[i];
    end
  end

  assign top   = dig_r[0];
  assign count = cnt_r;

endmodule

>>> rtl/char_lcd_write_sequencer.sv
// Command, data and cursor requests go from S_IDLE to S_BYTE, which registers the first strobe.
// Throughput: one strobe per cycle while out_stall is low; a byte is 1 strobe (8-bit) or 2 strobes (4-bit bus).
// Numbers: the bit-serial divide-by-ten unit yields each digit before the digits are strobed.
// A request is taken only when the sequencer is idle; strobes are held under out_stall.
// Reset: sequencer idle, no strobe pending, bus_mode set to 4-bit.
// -----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns one request into the enable-strobed bus writes of a character LCD.
// -----------------------------------------------------------------------------
`include "char_lcd_write_sequencer_macros.svh"

module char_lcd_write_sequencer
  import lws_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_byte_value,
  input  logic [1:0]  in_row,
  input  logic [3:0]  in_column,
  input  logic signed [31:0] in_number,
  // strobe channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reg_select,
  output logic [7:0]  out_bus_value,
  output logic        out_byte_done,
  output logic        out_last
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  state_t        state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic          nib_r, nib_nxt;
  logic          bus_mode_r;

  logic          out_valid_r, out_valid_nxt;
  logic          out_rs_r, out_rs_nxt;
  logic [7:0]    out_bus_r, out_bus_nxt;
  logic          out_done_r, out_done_nxt;
  logic          out_last_r, out_last_nxt;

  stk_ctl_t         stk_ctl;
  logic [3:0]       stk_digit;
  logic [3:0]       stk_top;
  logic [CW-1:0]    stk_count;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  div_stat_t        div_stat;
  logic             div_busy;
  logic [DIV_W-1:0] div_quot;

  logic [1:0]    row_eff;
  logic [7:0]    cursor_addr;
  logic [7:0]    cur_byte;
  logic          cur_last;
  logic          cur_rs;
  logic          out_free;

  lws_div10 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .stat     (div_stat),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  lws_dstack #(.MAX_DIGITS(MAX_DIGITS)) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stk_ctl),
    .digit_in (stk_digit),
    .top      (stk_top),
    .count    (stk_count)
  );

  // Clamp the row and form the cursor address
  assign row_eff     = ({1'b0, in_row} >= 3'(NUM_ROWS)) ? 2'(NUM_ROWS - 1) : in_row;
  assign cursor_addr = row_base(row_eff) + {4'h0, in_column};

  // Select the byte being sent and whether it ends the request
  always_comb begin
    unique case (op_r)
      OP_NUMBER: begin
        cur_byte = ASCII_ZERO + {4'h0, stk_top};
        cur_last = (stk_count == CW'(1));
      end
      OP_INIT: begin
        cur_byte = init_cmd(bus_mode_r, idx_r);
        cur_last = (idx_r == (bus_mode_r ? INIT4_LEN - 3'd1 : INIT8_LEN - 3'd1));
      end
      default: begin
        cur_byte = byte_r;
        cur_last = 1'b1;
      end
    endcase
  end

  assign cur_rs   = (op_r == OP_DATA) || (op_r == OP_NUMBER);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    idx_nxt       = idx_r;
    nib_nxt       = nib_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rs_nxt    = out_rs_r;
    out_bus_nxt   = out_bus_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;
    stk_ctl       = '0;
    stk_digit     = div_stat.digit;
    div_start     = 1'b0;
    div_dividend  = in_number;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_operation;
          byte_nxt = (in_operation == OP_CURSOR) ? cursor_addr : in_byte_value;
          idx_nxt  = 3'd0;
          nib_nxt  = 1'b0;
          unique case (in_operation)
            OP_CMD, OP_DATA, OP_CURSOR, OP_INIT: begin
              state_nxt = S_BYTE;
            end
            OP_NUMBER: begin
              priority if (in_number == 32'sd0) begin
                stk_ctl.push = 1'b1;
                stk_digit    = 4'd0;
                state_nxt    = S_BYTE;
              end else if (!in_number[31]) begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end else begin
                // drop negative numbers
                state_nxt = S_IDLE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_DIV: begin
        // Stack each digit; divide the quotient again while it is nonzero and the stack has room
        if (div_stat.done) begin
          stk_ctl.push = 1'b1;
          if (div_stat.q_nz && (stk_count < CW'(MAX_DIGITS - 1))) begin
            div_start    = 1'b1;
            div_dividend = div_quot;
          end else begin
            state_nxt = S_BYTE;
          end
        end
      end

      S_BYTE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rs_nxt    = cur_rs;
          if (bus_mode_r && !nib_r) begin
            out_bus_nxt  = {4'h0, cur_byte[7:4]};
            out_done_nxt = 1'b0;
            out_last_nxt = 1'b0;
            nib_nxt      = 1'b1;
          end else begin
            out_bus_nxt  = bus_mode_r ? {4'h0, cur_byte[3:0]} : cur_byte;
            out_done_nxt = 1'b1;
            out_last_nxt = cur_last;
            nib_nxt      = 1'b0;
            // Advance to the next byte of the request
            if (op_r == OP_NUMBER) begin
              stk_ctl.pop = 1'b1;
            end
            idx_nxt = idx_r + 3'd1;
            if (cur_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bus_mode_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        bus_mode_r <= cfg_wr_data;
      end
    end
  end

  // Request and strobe payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    byte_r     <= byte_nxt;
    idx_r      <= idx_nxt;
    nib_r      <= nib_nxt;
    out_rs_r   <= out_rs_nxt;
    out_bus_r  <= out_bus_nxt;
    out_done_r <= out_done_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_bus_value  = out_bus_r;
  assign out_byte_done  = out_done_r;
  assign out_last       = out_last_r;

  // Assertions
  `LWS_ASSERT_NOW(a_div_only_in_div, div_busy, state_r == S_DIV, "divider running outside digit phase")
  `LWS_ASSERT_NOW(a_digits_present, (state_r == S_BYTE) && (op_r == OP_NUMBER), stk_count != '0, "digit stack empty while sending a number")
  `LWS_ASSERT_NOW(a_high_nibble_narrow, out_valid_r && !out_done_r, out_bus_r[7:4] == 4'h0, "high nibble strobe wider than four bits")

endmodule

>>> sim/char_lcd_write_sequencer_tb.sv
// -----------------------------------------------------------------------------
// char_lcd_write_sequencer_tb
// Self-checking bench for the LCD write sequencer. A short table of requests
// runs first in both bus modes. Random request streams follow, with random
// gaps and stalls on both channels and one long receiver hold-off. Each
// request is expanded into its expected strobes in the bench, and every
// strobe the block emits is compared field by field in order.
// -----------------------------------------------------------------------------
module char_lcd_write_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lws_pkg::OP_CMD;
  import lws_pkg::OP_DATA;
  import lws_pkg::OP_CURSOR;
  import lws_pkg::OP_NUMBER;
  import lws_pkg::OP_INIT;

  localparam int MAX_DIGITS    = 10;
  localparam int DISPLAY_ROWS  = 4;
  localparam int DIR_N         = 25;
  localparam int PHASE_N       = 4;
  localparam int PHASE_ITEMS   = 86;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 5000;

  // Unused operation codes, all ignored by the block
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic RS_INSTR  = 1'b0;
  localparam logic RS_DATA   = 1'b1;
  localparam logic MODE_8BIT = 1'b0;
  localparam logic MODE_4BIT = 1'b1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [0:3][7:0] ROW_ADDR = {8'h80, 8'hC0, 8'h90, 8'hD0};
  localparam int INIT4_COUNT = 7;
  localparam int INIT8_COUNT = 5;
  localparam logic [0:6][7:0] INIT4_SEQ = {8'h33, 8'h32, 8'h28, 8'h0C, 8'h02, 8'h01, 8'h06};
  localparam logic [0:4][7:0] INIT8_SEQ = {8'h38, 8'h0C, 8'h02, 8'h01, 8'h06};

  // How the strobes of one request are expected
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_SINGLE
  } chk_e;

  typedef struct packed {
    logic        rs;
    logic [7:0]  bus;
    logic        done;
    logic        last;
  } strobe_t;

  typedef struct packed {
    logic               mode;
    logic [2:0]         op;
    logic [7:0]         bval;
    logic [1:0]         row;
    logic [3:0]         col;
    logic signed [31:0] num;
    chk_e               kind;
    logic               exp_rs;
    logic [7:0]         exp_bus;
  } req_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic               cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_operation;
  logic [7:0]         in_byte_value;
  logic [1:0]         in_row;
  logic [3:0]         in_column;
  logic signed [31:0] in_number;
  logic               out_valid;
  logic               out_stall;
  logic               out_reg_select;
  logic [7:0]         out_bus_value;
  logic               out_byte_done;
  logic               out_last;

  strobe_t strobe_q [$];
  req_t    pending_q [$];
  logic    model_mode = MODE_4BIT;
  bit      idle_en = 1'b1;
  bit      hold_req = 1'b0;
  int      err_cnt = 0;
  int      quiet_cycles = 0;

  // Directed requests; typed expectations only for single 8-bit strobes
  req_t dir_tab [0:DIR_N-1] = '{
    '{MODE_4BIT, OP_INIT,   8'h00, 2'd0, 4'd0,  32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_CMD,    8'h00, 2'd0, 4'd0,  32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_CMD,    8'hFF, 2'd3, 4'd15, 32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_DATA,   8'h00, 2'd0, 4'd0,  32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_DATA,   8'hFF, 2'd0, 4'd0,  32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_CURSOR, 8'h00, 2'd0, 4'd0,  32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_CURSOR, 8'h00, 2'd3, 4'd15, 32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_NUMBER, 8'h00, 2'd0, 4'd0,  32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_NUMBER, 8'h00, 2'd0, 4'd0,  32'h7FFFFFFF, CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_NUMBER, 8'h00, 2'd0, 4'd0,  32'hFFFFFFFF, CHK_NONE,    RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_NUMBER, 8'h00, 2'd0, 4'd0,  32'h80000000, CHK_NONE,    RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_RSVD5,  8'hFF, 2'd3, 4'd15, 32'h7FFFFFFF, CHK_NONE,    RS_INSTR, 8'h00},
    '{MODE_4BIT, OP_RSVD7,  8'hFF, 2'd3, 4'd15, 32'sd1,       CHK_NONE,    RS_INSTR, 8'h00},
    '{MODE_8BIT, OP_INIT,   8'h00, 2'd0, 4'd0,  32'sd0,       CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_8BIT, OP_CMD,    8'h00, 2'd0, 4'd0,  32'sd0,       CHK_SINGLE,  RS_INSTR, 8'h00},
    '{MODE_8BIT, OP_CMD,    8'hFF, 2'd0, 4'd0,  32'sd0,       CHK_SINGLE,  RS_INSTR, 8'hFF},
    '{MODE_8BIT, OP_DATA,   8'h00, 2'd0, 4'd0,  32'sd0,       CHK_SINGLE,  RS_DATA,  8'h00},
    '{MODE_8BIT, OP_DATA,   8'hA5, 2'd0, 4'd0,  32'sd0,       CHK_SINGLE,  RS_DATA,  8'hA5},
    '{MODE_8BIT, OP_CURSOR, 8'h00, 2'd0, 4'd0,  32'sd0,       CHK_SINGLE,  RS_INSTR, 8'h80},
    '{MODE_8BIT, OP_CURSOR, 8'h00, 2'd1, 4'd15, 32'sd0,       CHK_SINGLE,  RS_INSTR, 8'hCF},
    '{MODE_8BIT, OP_CURSOR, 8'h00, 2'd2, 4'd5,  32'sd0,       CHK_SINGLE,  RS_INSTR, 8'h95},
    '{MODE_8BIT, OP_NUMBER, 8'h00, 2'd0, 4'd0,  32'sd0,       CHK_SINGLE,  RS_DATA,  8'h30},
    '{MODE_8BIT, OP_NUMBER, 8'h00, 2'd0, 4'd0,  32'sd7,       CHK_SINGLE,  RS_DATA,  8'h37},
    '{MODE_8BIT, OP_NUMBER, 8'h00, 2'd0, 4'd0,  32'sd1234567890, CHK_PREDICT, RS_INSTR, 8'h00},
    '{MODE_8BIT, OP_RSVD6,  8'h5A, 2'd1, 4'd9,  32'sd42,      CHK_NONE,    RS_INSTR, 8'h00}
  };

  char_lcd_write_sequencer #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_reg_select(out_reg_select),
    .out_bus_value (out_bus_value),
    .out_byte_done (out_byte_done),
    .out_last      (out_last)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  // Queue the strobes of one byte for the given bus mode
  task automatic push_byte(input logic mode, input logic rs, input logic [7:0] b);
    strobe_t s;
    s.rs   = rs;
    s.last = 1'b0;
    if (mode == MODE_4BIT) begin
      s.bus  = {4'h0, b[7:4]};
      s.done = 1'b0;
      strobe_q.push_back(s);
      s.bus  = {4'h0, b[3:0]};
      s.done = 1'b1;
      strobe_q.push_back(s);
    end else begin
      s.bus  = b;
      s.done = 1'b1;
      strobe_q.push_back(s);
    end
  endtask

  // Expand one request into its bus strobes
  task automatic predict_strobes(input logic mode, input logic [2:0] op,
                                 input logic [7:0] bval, input logic [1:0] row,
                                 input logic [3:0] col, input logic signed [31:0] num);
    int          first;
    int          n;
    logic [1:0]  r;
    logic [31:0] v;
    logic [3:0]  dig [MAX_DIGITS];
    first = strobe_q.size();
    case (op)
      OP_CMD: push_byte(mode, RS_INSTR, bval);
      OP_DATA: push_byte(mode, RS_DATA, bval);
      OP_CURSOR: begin
        r = (row >= DISPLAY_ROWS) ? 2'(DISPLAY_ROWS - 1) : row;
        push_byte(mode, RS_INSTR, ROW_ADDR[r] + {4'h0, col});
      end
      OP_NUMBER: begin
        if (num == 0) begin
          push_byte(mode, RS_DATA, CHAR_ZERO);
        end else if (num > 0) begin
          // peel digits from the low end, keep at most MAX_DIGITS
          v = num;
          n = 0;
          while (v != 0 && n < MAX_DIGITS) begin
            dig[n] = 4'(v % 10);
            v = v / 10;
            n++;
          end
          for (int i = n - 1; i >= 0; i--) begin
            push_byte(mode, RS_DATA, CHAR_ZERO + {4'h0, dig[i]});
          end
        end
      end
      OP_INIT: begin
        if (mode == MODE_4BIT) begin
          for (int i = 0; i < INIT4_COUNT; i++) begin
            push_byte(mode, RS_INSTR, INIT4_SEQ[i]);
          end
        end else begin
          for (int i = 0; i < INIT8_COUNT; i++) begin
            push_byte(mode, RS_INSTR, INIT8_SEQ[i]);
          end
        end
      end
      default: ;
    endcase
    if (strobe_q.size() > first) begin
      strobe_q[strobe_q.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Present one request and hold it until accepted
  task automatic send_req(input req_t r);
    pending_q.push_back(r);
    in_operation  <= r.op;
    in_byte_value <= r.bval;
    in_row        <= r.row;
    in_column     <= r.col;
    in_number     <= r.num;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid for a random stretch, or go straight on
  task automatic sender_gap();
    int n;
    n = (idle_en && $urandom_range(0, 1) == 1) ? idle_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait until the block is drained and quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the monitor expand the last accepted request first
    @(posedge clk);
    while (strobe_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the bus mode with the block idle
  task automatic write_mode(input logic m);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_mode = m;
  endtask

  function automatic req_t random_req();
    req_t r;
    int   pick;
    r.mode    = model_mode;
    r.kind    = CHK_PREDICT;
    r.exp_rs  = RS_INSTR;
    r.exp_bus = 8'h00;
    r.bval    = 8'($urandom_range(0, 255));
    r.row     = 2'($urandom_range(0, 3));
    r.col     = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 22) r.op = OP_CMD;
    else if (pick < 44) r.op = OP_DATA;
    else if (pick < 62) r.op = OP_CURSOR;
    else if (pick < 80) r.op = OP_NUMBER;
    else if (pick < 93) r.op = OP_INIT;
    else r.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
    case ($urandom_range(0, 5))
      0: r.num = $urandom_range(1, 9);
      1: r.num = $urandom_range(10, 99999);
      2: r.num = 32'sd0;
      3: r.num = 32'h7FFFFFFF;
      default: r.num = $urandom;
    endcase
    return r;
  endfunction

  // Stimulus: reset, directed table, random phases, end of run
  initial begin
    logic phase_mode [PHASE_N];
    bit   phase_idle [PHASE_N];
    phase_mode = '{MODE_8BIT, MODE_4BIT, MODE_8BIT, MODE_4BIT};
    phase_idle = '{1'b1, 1'b0, 1'b1, 1'b1};
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_CMD;
    in_byte_value <= 8'h00;
    in_row        <= 2'd0;
    in_column     <= 4'd0;
    in_number     <= 32'sd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].mode != model_mode) begin
        write_mode(dir_tab[i].mode);
      end
      send_req(dir_tab[i]);
      sender_gap();
    end

    for (int p = 0; p < PHASE_N; p++) begin
      write_mode(phase_mode[p]);
      idle_en = phase_idle[p];
      // hold the receiver off once so requests back up behind it
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_req(random_req());
        sender_gap();
      end
    end

    wait_drained();
    if (strobe_q.size() != 0) begin
      $display("%0t: %0d expected strobes never arrived", $time, strobe_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver stall: random stretches plus one long hold-off on request
  initial begin
    int left;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        left = idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check strobes, predict accepted requests, run the watchdog
  always @(posedge clk) begin
    strobe_t got;
    strobe_t want;
    req_t    req;
    if (rst_n) begin
      // compare each strobe transaction with the oldest expectation
      if (out_valid && !out_stall) begin
        got = {out_reg_select, out_bus_value, out_byte_done, out_last};
        if (strobe_q.size() == 0) begin
          $display("%0t: unexpected strobe: actual rs=%0b bus=%02h done=%0b last=%0b",
                   $time, got.rs, got.bus, got.done, got.last);
          err_cnt++;
        end else begin
          want = strobe_q.pop_front();
          check_field("reg_select", {7'd0, want.rs}, {7'd0, got.rs});
          check_field("bus_value", want.bus, got.bus);
          check_field("byte_done", {7'd0, want.done}, {7'd0, got.done});
          check_field("last", {7'd0, want.last}, {7'd0, got.last});
        end
      end

      // expand each accepted request transaction
      if (in_valid && !in_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: request accepted with none presented", $time);
          err_cnt++;
        end else begin
          req = pending_q.pop_front();
          case (req.kind)
            CHK_PREDICT: predict_strobes(model_mode, in_operation, in_byte_value,
                                         in_row, in_column, in_number);
            CHK_SINGLE: begin
              want.rs   = req.exp_rs;
              want.bus  = req.exp_bus;
              want.done = 1'b1;
              want.last = 1'b1;
              strobe_q.push_back(want);
            end
            default: ;
          endcase
        end
      end

      // end the run if neither channel moves for too long
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
